[sv/ddrw_pkg.sv]
// Shared types, constants and helpers for the decimal digit register writer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ddrw_pkg;

   localparam int MAX_DIGITS = 8;
   localparam int MAX_UNITS  = 8;

   localparam int UNIT_W   = 3;
   localparam int NUMBER_W = 27;
   localparam int ADDR_W   = 5;
   localparam int DIGIT_W  = 4;
   localparam int POS_W    = 3;
   localparam int CFG_W    = 4;
   localparam int CSR_IDX_W = 2;

   // Reciprocal of ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2^27.
   localparam int RECIP_SHIFT = 30;
   localparam logic [NUMBER_W-1:0] RECIP_TEN = NUMBER_W'(((64'd1 << RECIP_SHIFT) + 9) / 10);
   localparam int PROD_W = 2 * NUMBER_W;

   localparam logic [CFG_W-1:0] RESET_DISPLAY_COUNT   = CFG_W'(1);
   localparam logic [CFG_W-1:0] RESET_DIGITS_PER_UNIT = CFG_W'(3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISPLAY_COUNT   = 2'd0,
      CSR_DIGITS_PER_UNIT = 2'd1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_CONVERT
   } ctrl_state_type;

   typedef struct packed {
      logic load;   // capture an accepted request
      logic step;   // emit one digit into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic req_ok;      // presented request passes the range checks
      logic last_digit;  // the digit about to be emitted is the final one
      logic slot_free;   // output register can take a beat this cycle
   } dp_status_type;

   // Smallest number that no longer fits in the given digit count.
   function automatic logic [NUMBER_W-1:0] pow10(input logic [CFG_W-1:0] ndig);
      logic [NUMBER_W-1:0] result;
      unique case (ndig)
         4'd0:    result = NUMBER_W'(1);
         4'd1:    result = NUMBER_W'(10);
         4'd2:    result = NUMBER_W'(100);
         4'd3:    result = NUMBER_W'(1000);
         4'd4:    result = NUMBER_W'(10000);
         4'd5:    result = NUMBER_W'(100000);
         4'd6:    result = NUMBER_W'(1000000);
         4'd7:    result = NUMBER_W'(10000000);
         default: result = NUMBER_W'(100000000);
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

[sv/ddrw_if.sv]
// Valid/ready channel interfaces for requests and register-write beats.
// Depends on ddrw_pkg for field widths.
`default_nettype none

interface ddrw_req_if import ddrw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [UNIT_W-1:0]   unit_index;
   logic [NUMBER_W-1:0] number_value;

   modport source (output valid, output unit_index, output number_value, input ready);
   modport sink   (input valid, input unit_index, input number_value, output ready);
endinterface

interface ddrw_rsp_if import ddrw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  register_address;
   logic [DIGIT_W-1:0] digit_value;
   logic               last_write;

   modport source (output valid, output register_address, output digit_value,
                   output last_write, input ready);
   modport sink   (input valid, input register_address, input digit_value,
                   input last_write, output ready);
endinterface

`default_nettype wire

[sv/ddrw_ctrl.sv]
// Controller state machine: accepts or drops requests and paces digit emission.
// Depends on ddrw_pkg for the state, command and status types.
`default_nettype none

module ddrw_ctrl import ddrw_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd,
   output ctrl_state_type     state
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.req_ok) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (status.slot_free && status.last_digit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && status.req_ok;
         end
         ST_CONVERT: begin
            cmd.step = status.slot_free;
         end
         default: ;
      endcase
   end

   assign state = state_ff;

endmodule

`default_nettype wire

[sv/ddrw_dp.sv]
// Datapath: configuration, request checks, divide-by-ten step and output register.
// Depends on ddrw_pkg for widths, constants and the command/status types.
`default_nettype none

module ddrw_dp import ddrw_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]    csr_write_data,
   input  wire logic [UNIT_W-1:0]   req_unit_index,
   input  wire logic [NUMBER_W-1:0] req_number_value,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [ADDR_W-1:0]        rsp_register_address,
   output logic [DIGIT_W-1:0]       rsp_digit_value,
   output logic                     rsp_last_write
);

   logic [CFG_W-1:0]    units_cfg_ff, digits_cfg_ff;
   logic [NUMBER_W-1:0] rem_ff, rem_in;
   logic [UNIT_W-1:0]   unit_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                valid_ff;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [DIGIT_W-1:0]  digit_ff, digit_in;
   logic                last_ff;

   logic [CFG_W-1:0]    units_sat, ndig;
   logic [PROD_W-1:0]   prod;
   logic [NUMBER_W-1:0] quot, quot_x10;

   always_ff @(posedge clock) begin
      if (reset) begin
         units_cfg_ff  <= RESET_DISPLAY_COUNT;
         digits_cfg_ff <= RESET_DIGITS_PER_UNIT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISPLAY_COUNT:   units_cfg_ff  <= csr_write_data;
            CSR_DIGITS_PER_UNIT: digits_cfg_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign units_sat = (units_cfg_ff > CFG_W'(MAX_UNITS)) ? CFG_W'(MAX_UNITS) : units_cfg_ff;
   assign ndig      = (digits_cfg_ff > CFG_W'(MAX_DIGITS)) ? CFG_W'(MAX_DIGITS) : digits_cfg_ff;

   assign status.req_ok = (ndig != '0)
                        && ({1'b0, req_unit_index} < units_sat)
                        && (req_number_value < pow10(ndig));
   assign status.last_digit = (CFG_W'(pos_ff) + CFG_W'(1)) == ndig;
   assign status.slot_free  = !valid_ff || rsp_ready;

   // Divide by ten through the reciprocal; the remainder is the digit.
   assign prod     = PROD_W'(rem_ff) * PROD_W'(RECIP_TEN);
   assign quot     = NUMBER_W'(prod >> RECIP_SHIFT);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign digit_in = DIGIT_W'(rem_ff - quot_x10);
   assign rem_in   = quot;
   assign addr_in  = ADDR_W'({2'b00, unit_ff} + {1'b0, unit_ff, 1'b0})
                   + ADDR_W'(pos_ff) + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff  <= req_number_value;
         unit_ff <= req_unit_index;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
      end
      if (cmd.step) begin
         addr_ff  <= addr_in;
         digit_ff <= digit_in;
         last_ff  <= status.last_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load) pos_ff <= '0;
         else if (cmd.step) pos_ff <= pos_ff + POS_W'(1);
         if (cmd.step) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_register_address = addr_ff;
   assign rsp_digit_value      = digit_ff;
   assign rsp_last_write       = last_ff;

endmodule

`default_nettype wire

[sv/decimal_digit_register_writer_unit.sv]
// Top level of the decimal digit register writer: controller plus datapath.
// Depends on ddrw_pkg, ddrw_if, ddrw_ctrl and ddrw_dp.
`default_nettype none

// A request carries a display unit index and a binary number. It is dropped,
// with no beats out, when the unit is not below display_count (saturated to
// eight, zero rejects all) or the number does not fit in digits_per_unit
// decimal digits (saturated to eight, zero rejects all). Otherwise one
// register-write beat per digit leaves on rsp, least significant digit first,
// at address unit*3 + position + 1, with last_write set on the final beat.
// Timing: a request is taken while the block is idle; a dropped one leaves it
// idle. An accepted number then goes digit by digit through the shared
// divide-by-ten step, and the next request is taken once the final digit has
// been stepped; a step waits while the output register is still full.
// The output register lets the next request enter while the final beat waits.
// Configuration writes are taken at any time but belong to idle periods.
module decimal_digit_register_writer_unit import ddrw_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data,
   ddrw_req_if.sink                  req_bus,
   ddrw_rsp_if.source                rsp_bus
);

   dp_cmd_type     cmd;
   dp_status_type  status;
   ctrl_state_type state;

   // Sequence requests: accept or drop, then one step per digit.
   ddrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd),
      .state     (state)
   );

   // Hold configuration, check requests, divide and drive the beat register.
   ddrw_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_unit_index       (req_bus.unit_index),
      .req_number_value     (req_bus.number_value),
      .cmd                  (cmd),
      .status               (status),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_register_address (rsp_bus.register_address),
      .rsp_digit_value      (rsp_bus.digit_value),
      .rsp_last_write       (rsp_bus.last_write)
   );

   // Never take a request while a number is still being converted.
   a_no_accept_in_convert: assert property (@(posedge clock) disable iff (reset)
      (state == ST_CONVERT) |-> !req_bus.ready)
      else $error("request ready during conversion");

   // A digit stepped in must show up as a valid beat with a decimal value.
   a_step_makes_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (rsp_bus.valid && (rsp_bus.digit_value <= DIGIT_W'(9))))
      else $error("stepped digit missing or not decimal");

   // The final digit step ends the conversion and marks the beat last.
   a_last_ends_convert: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.last_digit) |=> (rsp_bus.last_write && state == ST_IDLE))
      else $error("final digit did not close the number");

   // Load only from idle, never together with a step.
   a_load_from_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state == ST_IDLE && !cmd.step))
      else $error("load outside idle");

endmodule

`default_nettype wire

[verif/tb_decimal_digit_register_writer_unit.sv]
// Self-checking testbench for decimal_digit_register_writer_unit: directed and random requests
// with random idling on both channels, predicted digit writes checked beat by beat.
// Depends on ddrw_pkg, ddrw_if and the block's RTL.
`default_nettype none

module tb_decimal_digit_register_writer_unit import ddrw_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Longest stretch with no beat on either channel before the run is declared hung.
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   // Cycles to let a dropped request clear the block before touching registers.
   localparam int unsigned SETTLE_CYCLES  = 2 * (MAX_DIGITS + 1) + 2;
   // Requests sent over the whole run, directed ones included.
   localparam int unsigned TOTAL_ITEMS    = 410;
   localparam int unsigned PHASE_ITEMS    = 45;
   localparam int unsigned MAX_GAP        = 18;

   // Indexes past the register list; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = CSR_IDX_W'(3);

   typedef struct packed {
      logic [ADDR_W-1:0]  register_address;
      logic [DIGIT_W-1:0] digit_value;
      logic               last_write;
   } digit_write_type;

   // Keeps its own copy of the configuration, expands each accepted number into the
   // digit writes it must cause and matches the writes that leave the block.
   class digit_write_ledger_type;
      logic [CFG_W-1:0] display_count;
      logic [CFG_W-1:0] digits_per_unit;
      digit_write_type  pending_writes[$];
      int unsigned      converted;
      int unsigned      dropped;
      int unsigned      writes_seen;
      int unsigned      errors;

      function new();
         display_count   = RESET_DISPLAY_COUNT;
         digits_per_unit = RESET_DIGITS_PER_UNIT;
         converted   = 0;
         dropped     = 0;
         writes_seen = 0;
         errors      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         if (idx == CSR_DISPLAY_COUNT) begin
            display_count = data;
         end else if (idx == CSR_DIGITS_PER_UNIT) begin
            digits_per_unit = data;
         end
      endfunction

      function int unsigned effective_units();
         return (display_count > MAX_UNITS) ? MAX_UNITS : int'(display_count);
      endfunction

      function int unsigned effective_digits();
         return (digits_per_unit > MAX_DIGITS) ? MAX_DIGITS : int'(digits_per_unit);
      endfunction

      function int unsigned decade(int unsigned n);
         int unsigned p;
         p = 1;
         for (int unsigned i = 0; i < n; i++) p = p * 10;
         return p;
      endfunction

      function void note_number(logic [UNIT_W-1:0] unit, logic [NUMBER_W-1:0] number);
         int unsigned      units;
         int unsigned      ndig;
         logic [NUMBER_W-1:0] rest;
         digit_write_type  w;
         units = effective_units();
         ndig  = effective_digits();
         if (ndig == 0 || unit >= units || number > decade(ndig) - 1) begin
            dropped++;
            return;
         end
         converted++;
         rest = number;
         for (int unsigned i = 0; i < ndig; i++) begin
            w.register_address = ADDR_W'(int'(unit) * 3 + i + 1);
            w.digit_value      = DIGIT_W'(rest % 10);
            w.last_write       = (i + 1 == ndig);
            rest = rest / 10;
            pending_writes.push_back(w);
         end
      endfunction

      function void match_write(digit_write_type got);
         digit_write_type want;
         writes_seen++;
         if (pending_writes.size() == 0) begin
            $error("unexpected write: register_address %0d digit_value %0d last_write %0d",
                   got.register_address, got.digit_value, got.last_write);
            errors++;
            return;
         end
         want = pending_writes.pop_front();
         if (got.register_address !== want.register_address) begin
            $error("register_address: expected %0d, actual %0d",
                   want.register_address, got.register_address);
            errors++;
         end
         if (got.digit_value !== want.digit_value) begin
            $error("digit_value: expected %0d, actual %0d", want.digit_value, got.digit_value);
            errors++;
         end
         if (got.last_write !== want.last_write) begin
            $error("last_write: expected %0d, actual %0d", want.last_write, got.last_write);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;

   // Per-phase switches that turn idling off on one side or both.
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   digit_write_ledger_type ledger = new();

   ddrw_req_if req_bus ();
   ddrw_rsp_if rsp_bus ();

   decimal_digit_register_writer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Present one request after a random gap and hold it until the block takes the beat.
   // Valid stays high across back-to-back beats so it is never toggled within one step.
   task automatic send_number(input logic [UNIT_W-1:0] unit, input logic [NUMBER_W-1:0] number);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.unit_index   <= unit;
      req_bus.number_value <= number;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      ledger.note_number(unit, number);
   endtask

   // Drop valid and hold the sender until every predicted write has left the block;
   // optionally wait further so a dropped request has cleared.
   task automatic hold_until_drained(input bit settle);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (ledger.pending_writes.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; the task then waits with enable low so enable edges fall in separate steps.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ledger.write_register(idx, data);
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] ndig);
      hold_until_drained(1'b1);
      write_csr(CSR_DISPLAY_COUNT, count);
      write_csr(CSR_DIGITS_PER_UNIT, ndig);
   endtask

   // Result side: stall a random number of cycles per beat, then take one beat and check it.
   initial begin : result_sink
      int unsigned     stall;
      digit_write_type got;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.register_address = rsp_bus.register_address;
         got.digit_value      = rsp_bus.digit_value;
         got.last_write       = rsp_bus.last_write;
         ledger.match_write(got);
      end
   end

   // Hang detector: any accepted beat on either channel resets the count.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_decimal_digit_register_writer_unit: done, errors");
      $finish;
   end

   initial begin : stimulus
      int unsigned         phase;
      int unsigned         units;
      int unsigned         ndig;
      int unsigned         width;
      logic [UNIT_W-1:0]   unit;
      logic [NUMBER_W-1:0] number;

      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_DISPLAY_COUNT;
      csr_write_data       = '0;
      req_bus.valid        = 1'b0;
      req_bus.unit_index   = '0;
      req_bus.number_value = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: one unit, three digits. Hit both edges of the range and both drops.
      send_number(0, 0);
      send_number(0, 999);
      send_number(0, 1000);
      send_number(1, 5);
      send_number(0, 507);

      // Widest legal setting; all-ones number drops but sets every input bit.
      set_config(8, 8);
      send_number(7, 99999999);
      send_number(0, 100000000);
      send_number(3, 0);
      send_number(7, {NUMBER_W{1'b1}});
      send_number(5, 12345678);

      // Zero digits: nothing may come out.
      set_config(8, 0);
      send_number(0, 0);

      // Zero units rejects everything, even with digits saturating.
      set_config(0, 15);
      send_number(0, 42);

      // Both registers above their maxima saturate to eight.
      set_config(15, 9);
      send_number(7, 99999999);
      send_number(2, 80706050);

      // Writes past the register list leave the setting untouched.
      hold_until_drained(1'b1);
      write_csr(CSR_SPARE_2, '0);
      write_csr(CSR_SPARE_3, {CFG_W{1'b1}});
      send_number(7, 13579);

      // Single digit, neighbouring units overlap nothing; ten overflows.
      set_config(8, 1);
      send_number(7, 9);
      send_number(6, 10);
      send_number(0, 0);

      // Random part: phases of random settings, mostly well-formed numbers, some noise,
      // until the run has sent its full count of requests.
      phase = 0;
      while (ledger.converted + ledger.dropped < TOTAL_ITEMS) begin
         case (phase)
            0:       set_config(8, 8);
            1:       set_config(1, 1);
            2:       set_config(15, 15);
            default: set_config(CFG_W'($urandom_range(1, 15)), CFG_W'($urandom_range(1, 15)));
         endcase
         if (phase == 0) begin
            req_quiet = 1'b1;
            rsp_quiet = 1'b1;
         end else begin
            req_quiet = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         units = ledger.effective_units();
         ndig  = ledger.effective_digits();
         for (int unsigned n = 0;
              n < PHASE_ITEMS && ledger.converted + ledger.dropped < TOTAL_ITEMS; n++) begin
            if (units == 0 || ndig == 0 || $urandom_range(0, 4) == 0) begin
               unit = UNIT_W'($urandom_range(0, 7));
               case ($urandom_range(0, 2))
                  0:       number = NUMBER_W'($urandom);
                  1:       number = NUMBER_W'(ledger.decade(ndig));
                  default: number = NUMBER_W'($urandom_range(0, 999));
               endcase
            end else begin
               unit   = UNIT_W'($urandom_range(0, units - 1));
               width  = $urandom_range(1, ndig);
               number = NUMBER_W'($urandom_range(0, ledger.decade(width) - 1));
            end
            send_number(unit, number);
            // Now and then, hold off until the block has emptied completely.
            if ($urandom_range(0, 29) == 0) hold_until_drained(1'b0);
         end
         phase++;
      end

      hold_until_drained(1'b1);
      if (ledger.pending_writes.size() != 0) begin
         $error("%0d predicted writes never arrived", ledger.pending_writes.size());
         ledger.errors++;
      end
      $display("covered %0d converted numbers and %0d dropped requests over %0d random settings,",
               ledger.converted, ledger.dropped, phase);
      $display("checking %0d digit writes with random stalls on both channels",
               ledger.writes_seen);
      if (ledger.errors == 0) begin
         $display("tb_decimal_digit_register_writer_unit: done, clean");
      end else begin
         $display("tb_decimal_digit_register_writer_unit: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

[decimal_digit_register_writer_unit.f]
sv/ddrw_pkg.sv
sv/ddrw_if.sv
sv/ddrw_ctrl.sv
sv/ddrw_dp.sv
sv/decimal_digit_register_writer_unit.sv
verif/tb_decimal_digit_register_writer_unit.sv
